// File: rtl/hrz_pkg.sv
// ----------------------------------------------------------------------------
// hrz_pkg
// Shared types and constants of the lumped-mass assembler for ten-node
// tetrahedra.
// ----------------------------------------------------------------------------
package hrz_pkg;

   localparam int NODES_DEFAULT = 4096;
   localparam int NODE_W        = 12;
   localparam int COORD_W       = 32;
   localparam int MASS_W        = 64;
   localparam int COUNT_W       = 32;
   localparam int STEP_W        = 5;

   // quotient digits of the divide-by-15 unit, four bits each
   localparam int DIV_DIGITS    = 22;

   localparam logic [2:0] ACT_LOAD_X   = 3'd0;
   localparam logic [2:0] ACT_LOAD_Y   = 3'd1;
   localparam logic [2:0] ACT_LOAD_Z   = 3'd2;
   localparam logic [2:0] ACT_ASSEMBLE = 3'd3;
   localparam logic [2:0] ACT_READ     = 3'd4;

   typedef struct packed {
      logic [2:0]                action;
      logic signed [COORD_W-1:0] coordinate;
      logic [NODE_W-1:0]         vertex0;
      logic [NODE_W-1:0]         vertex1;
      logic [NODE_W-1:0]         vertex2;
      logic [NODE_W-1:0]         vertex3;
      logic [NODE_W-1:0]         edge_node0;
      logic [NODE_W-1:0]         edge_node1;
      logic [NODE_W-1:0]         edge_node2;
      logic [NODE_W-1:0]         edge_node3;
      logic [NODE_W-1:0]         edge_node4;
      logic [NODE_W-1:0]         edge_node5;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]        node;
      logic signed [MASS_W-1:0] mass;
      logic [COUNT_W-1:0]       elements_done;
   } rsp_type;

   typedef struct packed {
      logic              latch;
      logic              load;
      logic              count;
      logic              fetch;
      logic              mul;
      logic              div_start;
      logic              div_step;
      logic              share_ld;
      logic              upd;
      logic              clear;
      logic              rsp_load;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic rsp_free;
   } sts_type;

endpackage

// File: rtl/hrz_lumped_mass_assembly.sv
// Loads and unsupported actions are taken in the idle state; a read passes RDREQ and
// waits in RDOUT until the result register is free. An assemble runs 5 corner fetch
// steps, 13 multiplier slots, 24 divider steps and ten mass read-modify-write updates,
// each a read step and a write step. Items are taken one at a time; a waiting result
// does not block loads or assembles. Synchronous reset clears control and counters,
// then a sweep zeroes every mass address in turn, during which no item is accepted.
// ----------------------------------------------------------------------------
// hrz_lumped_mass_assembly
// Lumped-mass assembler for ten-node tetrahedra: coordinate load, element
// assembly with exact triple product, and node mass readback.
// ----------------------------------------------------------------------------
module hrz_lumped_mass_assembly #(
   parameter int NODES = hrz_pkg::NODES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hrz_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hrz_pkg::rsp_type rsp_item
);
   import hrz_pkg::*;

   cmd_type cmd;
   sts_type sts;

   hrz_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_item.action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   hrz_dpath #(.NODES(NODES)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// File: rtl/hrz_ram.sv
// ----------------------------------------------------------------------------
// hrz_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hrz_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/hrz_ctrl.sv
// ----------------------------------------------------------------------------
// hrz_ctrl
// Sequencer: mass clearing sweep, item decode, and the fetch, multiply,
// divide and update phases of an element, and mass reads.
// ----------------------------------------------------------------------------
module hrz_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [2:0]       req_action,
   output logic             req_stall,
   input  hrz_pkg::sts_type sts,
   output hrz_pkg::cmd_type cmd
);
   import hrz_pkg::*;

   localparam logic [STEP_W-1:0] FETCH_LAST = STEP_W'(4);
   localparam logic [STEP_W-1:0] MULT_LAST  = STEP_W'(12);
   localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DIV_DIGITS + 1);
   localparam logic [STEP_W-1:0] UPD_LAST   = STEP_W'(19);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_FETCH = 8'b0000_0100,
      ST_MULT  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_UPD   = 8'b0010_0000,
      ST_RDREQ = 8'b0100_0000,
      ST_RDOUT = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff + STEP_W'(1);
      cmd       = '0;
      cmd.step  = step_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            step_in   = '0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               unique case (req_action) inside
                  ACT_LOAD_X, ACT_LOAD_Y, ACT_LOAD_Z: cmd.load = 1'b1;
                  ACT_ASSEMBLE: begin
                     cmd.count = 1'b1;
                     state_in  = ST_FETCH;
                  end
                  ACT_READ: state_in = ST_RDREQ;
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            if (step_ff == FETCH_LAST) begin
               state_in = ST_MULT;
               step_in  = '0;
            end
         end
         ST_MULT: begin
            cmd.mul = 1'b1;
            if (step_ff == MULT_LAST) begin
               state_in = ST_DIV;
               step_in  = '0;
            end
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               cmd.div_start = 1'b1;
            end else if (step_ff == DIV_LAST) begin
               cmd.share_ld = 1'b1;
               state_in     = ST_UPD;
               step_in      = '0;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_UPD: begin
            cmd.upd = 1'b1;
            if (step_ff == UPD_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_RDREQ: state_in = ST_RDOUT;
         ST_RDOUT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: rtl/hrz_dpath.sv
// ----------------------------------------------------------------------------
// hrz_dpath
// Datapath: coordinate and mass memories, shared multiplier with triple
// product accumulator, divide-by-15 digit unit and saturating mass update.
// ----------------------------------------------------------------------------
module hrz_dpath #(
   parameter int NODES = hrz_pkg::NODES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  hrz_pkg::cmd_type cmd,
   output hrz_pkg::sts_type sts,
   input  hrz_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hrz_pkg::rsp_type rsp_item
);
   import hrz_pkg::*;

   localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NODES - 1);
   localparam int DVD_W = 4 * DIV_DIGITS;

   localparam logic signed [MASS_W-1:0] MASS_MAX = {1'b0, {(MASS_W-1){1'b1}}};
   localparam logic signed [MASS_W-1:0] MASS_MIN = {1'b1, {(MASS_W-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_LOAD   = 3'd1,
      OP_MINOR0 = 3'd2,
      OP_MINOR1 = 3'd3,
      OP_MINOR2 = 3'd4,
      OP_SLOAD  = 3'd5,
      OP_SLO    = 3'd6,
      OP_SHI    = 3'd7
   } mop_type;

   function automatic logic in_range(input logic [NODE_W-1:0] n);
      return 32'(n) < 32'(NODES);
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [NODE_W-1:0] n);
      return AW'(n);
   endfunction

   function automatic logic signed [MASS_W-1:0] sat_share(input logic [DVD_W-1:0] m,
                                                          input logic neg);
      logic big;
      big = |m[DVD_W-1:MASS_W-1];
      if (neg) begin
         return big ? MASS_MIN : -$signed(m[MASS_W-1:0]);
      end
      return big ? MASS_MAX : $signed(m[MASS_W-1:0]);
   endfunction

   function automatic logic signed [MASS_W-1:0] sat_add(input logic signed [MASS_W-1:0] a,
                                                        input logic signed [MASS_W-1:0] b);
      logic [MASS_W:0] sum;
      sum = {a[MASS_W-1], a} + {b[MASS_W-1], b};
      if (sum[MASS_W] != sum[MASS_W-1]) begin
         return sum[MASS_W] ? MASS_MIN : MASS_MAX;
      end
      return $signed(sum[MASS_W-1:0]);
   endfunction

   // item
   req_type item_ff, item_in;
   assign item_in = cmd.latch ? req_item : item_ff;

   // coordinate memories
   logic [NODE_W-1:0]  corner_node;
   logic [COORD_W-1:0] x_rd, y_rd, z_rd;
   logic               x_we, y_we, z_we;
   logic               ld_ok;

   always_comb begin
      case (cmd.step[1:0])
         2'd0:    corner_node = item_ff.vertex0;
         2'd1:    corner_node = item_ff.vertex1;
         2'd2:    corner_node = item_ff.vertex2;
         default: corner_node = item_ff.vertex3;
      endcase
   end

   assign ld_ok = cmd.load && in_range(req_item.vertex0);
   assign x_we  = ld_ok && (req_item.action == ACT_LOAD_X);
   assign y_we  = ld_ok && (req_item.action == ACT_LOAD_Y);
   assign z_we  = ld_ok && (req_item.action == ACT_LOAD_Z);

   hrz_ram #(.WIDTH(COORD_W), .DEPTH(NODES), .AW(AW)) u_x_ram (
      .clock(clock), .wr_en(x_we), .wr_addr(addr_of(req_item.vertex0)),
      .wr_data(req_item.coordinate), .rd_addr(addr_of(corner_node)), .rd_data(x_rd)
   );
   hrz_ram #(.WIDTH(COORD_W), .DEPTH(NODES), .AW(AW)) u_y_ram (
      .clock(clock), .wr_en(y_we), .wr_addr(addr_of(req_item.vertex0)),
      .wr_data(req_item.coordinate), .rd_addr(addr_of(corner_node)), .rd_data(y_rd)
   );
   hrz_ram #(.WIDTH(COORD_W), .DEPTH(NODES), .AW(AW)) u_z_ram (
      .clock(clock), .wr_en(z_we), .wr_addr(addr_of(req_item.vertex0)),
      .wr_data(req_item.coordinate), .rd_addr(addr_of(corner_node)), .rd_data(z_rd)
   );

   // corner capture: p0, then differences p0 - p1, p0 - p2, p0 - p3
   logic                      corner_ok_ff, corner_ok_in;
   logic signed [COORD_W-1:0] vx, vy, vz;
   logic signed [COORD_W-1:0] p0x_ff, p0y_ff, p0z_ff, p0x_in, p0y_in, p0z_in;
   logic signed [COORD_W:0]   dx_ff [3], dy_ff [3], dz_ff [3];
   logic signed [COORD_W:0]   dx_in [3], dy_in [3], dz_in [3];

   assign corner_ok_in = in_range(corner_node);
   assign vx = corner_ok_ff ? $signed(x_rd) : '0;
   assign vy = corner_ok_ff ? $signed(y_rd) : '0;
   assign vz = corner_ok_ff ? $signed(z_rd) : '0;

   always_comb begin
      p0x_in = p0x_ff;
      p0y_in = p0y_ff;
      p0z_in = p0z_ff;
      for (int k = 0; k < 3; k++) begin
         dx_in[k] = dx_ff[k];
         dy_in[k] = dy_ff[k];
         dz_in[k] = dz_ff[k];
      end
      if (cmd.fetch) begin
         case (cmd.step[2:0])
            3'd1: begin
               p0x_in = vx;
               p0y_in = vy;
               p0z_in = vz;
            end
            3'd2, 3'd3, 3'd4: begin
               for (int k = 0; k < 3; k++) begin
                  if (cmd.step[2:0] == 3'(k + 2)) begin
                     dx_in[k] = {p0x_ff[COORD_W-1], p0x_ff} - {vx[COORD_W-1], vx};
                     dy_in[k] = {p0y_ff[COORD_W-1], p0y_ff} - {vy[COORD_W-1], vy};
                     dz_in[k] = {p0z_ff[COORD_W-1], p0z_ff} - {vz[COORD_W-1], vz};
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // multiplier schedule: three 2x2 minors, then S = ax*m0 + ay*m1 + az*m2,
   // each minor split into a low 34-bit and a high signed part
   logic signed [66:0]  m_ff [3], m_in [3];
   logic signed [66:0]  acc_ff, acc_in;
   logic signed [34:0]  mul_a, mul_b;
   logic signed [69:0]  prod_ff, prod_in;
   logic signed [101:0] s_ff, s_in;
   mop_type             op_ff, op_in, op_sel;
   logic signed [34:0]  ax, ay, az, bx, by, bz, cx, cy, cz;
   logic signed [34:0]  ml [3], mh [3];

   assign ax = {{2{dx_ff[0][COORD_W]}}, dx_ff[0]};
   assign ay = {{2{dy_ff[0][COORD_W]}}, dy_ff[0]};
   assign az = {{2{dz_ff[0][COORD_W]}}, dz_ff[0]};
   assign bx = {{2{dx_ff[1][COORD_W]}}, dx_ff[1]};
   assign by = {{2{dy_ff[1][COORD_W]}}, dy_ff[1]};
   assign bz = {{2{dz_ff[1][COORD_W]}}, dz_ff[1]};
   assign cx = {{2{dx_ff[2][COORD_W]}}, dx_ff[2]};
   assign cy = {{2{dy_ff[2][COORD_W]}}, dy_ff[2]};
   assign cz = {{2{dz_ff[2][COORD_W]}}, dz_ff[2]};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ml[k] = $signed({1'b0, m_ff[k][33:0]});
         mh[k] = $signed({{2{m_ff[k][66]}}, m_ff[k][66:34]});
      end
   end

   always_comb begin
      mul_a  = ax;
      mul_b  = ml[0];
      op_sel = OP_NONE;
      case (cmd.step[3:0])
         4'd0:  begin mul_a = by; mul_b = cz;    op_sel = OP_LOAD;   end
         4'd1:  begin mul_a = bz; mul_b = cy;    op_sel = OP_MINOR0; end
         4'd2:  begin mul_a = bz; mul_b = cx;    op_sel = OP_LOAD;   end
         4'd3:  begin mul_a = bx; mul_b = cz;    op_sel = OP_MINOR1; end
         4'd4:  begin mul_a = bx; mul_b = cy;    op_sel = OP_LOAD;   end
         4'd5:  begin mul_a = by; mul_b = cx;    op_sel = OP_MINOR2; end
         4'd6:  begin mul_a = ax; mul_b = ml[0]; op_sel = OP_SLOAD;  end
         4'd7:  begin mul_a = ax; mul_b = mh[0]; op_sel = OP_SHI;    end
         4'd8:  begin mul_a = ay; mul_b = ml[1]; op_sel = OP_SLO;    end
         4'd9:  begin mul_a = ay; mul_b = mh[1]; op_sel = OP_SHI;    end
         4'd10: begin mul_a = az; mul_b = ml[2]; op_sel = OP_SLO;    end
         4'd11: begin mul_a = az; mul_b = mh[2]; op_sel = OP_SHI;    end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign op_in   = cmd.mul ? op_sel : OP_NONE;

   always_comb begin
      logic signed [66:0]  p67;
      logic signed [101:0] plo, phi;
      p67    = $signed(prod_ff[66:0]);
      plo    = {{32{prod_ff[69]}}, prod_ff};
      phi    = $signed({prod_ff[67:0], 34'b0});
      acc_in = acc_ff;
      s_in   = s_ff;
      for (int k = 0; k < 3; k++) begin
         m_in[k] = m_ff[k];
      end
      case (op_ff)
         OP_LOAD:   acc_in  = p67;
         OP_MINOR0: m_in[0] = acc_ff - p67;
         OP_MINOR1: m_in[1] = acc_ff - p67;
         OP_MINOR2: m_in[2] = acc_ff - p67;
         OP_SLOAD:  s_in    = plo;
         OP_SLO:    s_in    = s_ff + plo;
         OP_SHI:    s_in    = s_ff + phi;
         default: ;
      endcase
   end

   // |S| >> 16 divided by 15 one hex digit a step; /120 and /30 follow by shifts
   logic               neg_ff, neg_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [3:0]         rem_ff, rem_in;
   logic [101:0]       s_mag;
   logic [7:0]         cur;
   logic [12:0]        recip;
   logic [3:0]         qd;
   logic [7:0]         qd15;
   logic signed [MASS_W-1:0] cshare_ff, cshare_in, eshare_ff, eshare_in;

   assign s_mag = s_ff[101] ? 102'(-s_ff) : 102'(s_ff);
   assign cur   = {rem_ff, dvd_ff[DVD_W-1 -: 4]};
   assign recip = (13'(cur) + 13'd1) * 13'd17;
   assign qd    = recip[11:8];
   assign qd15  = {qd, 4'b0} - {4'b0, qd};

   always_comb begin
      neg_in    = neg_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      cshare_in = cshare_ff;
      eshare_in = eshare_ff;
      if (cmd.div_start) begin
         neg_in = s_ff[101];
         dvd_in = DVD_W'(s_mag[101:16]);
         rem_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[DVD_W-5:0], qd};
         rem_in = 4'(cur - qd15);
      end
      if (cmd.share_ld) begin
         cshare_in = sat_share(dvd_ff >> 3, neg_ff);
         eshare_in = sat_share(dvd_ff >> 1, !neg_ff);
      end
   end

   // mass memory: clearing sweep, read-modify-write updates, reads
   logic [3:0]               upd_idx;
   logic [NODE_W-1:0]        upd_node, mass_node;
   logic                     node_ok_ff, node_ok_in;
   logic [MASS_W-1:0]        mass_rd;
   logic signed [MASS_W-1:0] mass_sum;
   logic                     mass_we;
   logic [AW-1:0]            mass_wr_addr;
   logic [MASS_W-1:0]        mass_wr_data;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;

   assign upd_idx = cmd.step[4:1];

   always_comb begin
      case (upd_idx)
         4'd0:    upd_node = item_ff.vertex0;
         4'd1:    upd_node = item_ff.vertex1;
         4'd2:    upd_node = item_ff.vertex2;
         4'd3:    upd_node = item_ff.vertex3;
         4'd4:    upd_node = item_ff.edge_node0;
         4'd5:    upd_node = item_ff.edge_node1;
         4'd6:    upd_node = item_ff.edge_node2;
         4'd7:    upd_node = item_ff.edge_node3;
         4'd8:    upd_node = item_ff.edge_node4;
         default: upd_node = item_ff.edge_node5;
      endcase
   end

   assign mass_node    = cmd.upd ? upd_node : item_ff.vertex0;
   assign node_ok_in   = in_range(mass_node);
   assign mass_sum     = sat_add($signed(mass_rd), (upd_idx < 4'd4) ? cshare_ff : eshare_ff);
   assign mass_we      = cmd.clear || (cmd.upd && cmd.step[0] && node_ok_ff);
   assign mass_wr_addr = cmd.clear ? clr_addr_ff : addr_of(upd_node);
   assign mass_wr_data = cmd.clear ? '0 : mass_sum;
   assign clr_addr_in  = cmd.clear ? clr_addr_ff + AW'(1) : clr_addr_ff;

   hrz_ram #(.WIDTH(MASS_W), .DEPTH(NODES), .AW(AW)) u_mass_ram (
      .clock(clock), .wr_en(mass_we), .wr_addr(mass_wr_addr),
      .wr_data(mass_wr_data), .rd_addr(addr_of(mass_node)), .rd_data(mass_rd)
   );

   // element count and result register
   logic [COUNT_W-1:0] elem_ff, elem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   assign elem_in      = cmd.count ? elem_ff + COUNT_W'(1) : elem_ff;
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_item_in = rsp_item_ff;
      if (cmd.rsp_load) begin
         rsp_item_in.node          = item_ff.vertex0;
         rsp_item_in.mass          = node_ok_ff ? $signed(mass_rd) : '0;
         rsp_item_in.elements_done = elem_ff;
      end
   end

   assign sts.clr_last = (clr_addr_ff == LAST_ADDR);
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item     = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_NONE;
         clr_addr_ff  <= '0;
         elem_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_ff        <= op_in;
         clr_addr_ff  <= clr_addr_in;
         elem_ff      <= elem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      corner_ok_ff <= corner_ok_in;
      node_ok_ff   <= node_ok_in;
      p0x_ff       <= p0x_in;
      p0y_ff       <= p0y_in;
      p0z_ff       <= p0z_in;
      for (int k = 0; k < 3; k++) begin
         dx_ff[k] <= dx_in[k];
         dy_ff[k] <= dy_in[k];
         dz_ff[k] <= dz_in[k];
         m_ff[k]  <= m_in[k];
      end
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      s_ff        <= s_in;
      neg_ff      <= neg_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cshare_ff   <= cshare_in;
      eshare_ff   <= eshare_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// File: tb/hrz_mass_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrz_mass_checker
// Watches both channels of the lumped-mass assembler. Keeps its own copy of
// the coordinate and mass stores and the element counter, and computes the
// expected answer of every read. Each accepted result is compared field by
// field with the oldest expected one.
// ----------------------------------------------------------------------------
module hrz_mass_checker
   import hrz_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_item,
   output int      error_count,
   output int      pending_count
);

   localparam logic signed [127:0] CORNER_DIV = 128'sd7864320;   // 120 * 2^16
   localparam logic signed [127:0] EDGE_DIV   = 128'sd1966080;   // 30 * 2^16
   localparam logic signed [127:0] WIDE_MAX   = 128'sd9223372036854775807;
   localparam logic signed [127:0] WIDE_MIN   = -128'sd9223372036854775808;
   localparam logic signed [63:0]  MASS_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0]  MASS_MIN   = 64'sh8000_0000_0000_0000;

   logic signed [31:0] x_coord [NODES_DEFAULT];
   logic signed [31:0] y_coord [NODES_DEFAULT];
   logic signed [31:0] z_coord [NODES_DEFAULT];
   logic signed [63:0] node_mass [NODES_DEFAULT];
   logic [31:0]        elements_seen;
   rsp_type            mass_expected [$];

   assign pending_count = mass_expected.size();

   function automatic logic signed [63:0] clamp_share(input logic signed [127:0] q);
      if (q > WIDE_MAX) return MASS_MAX;
      if (q < WIDE_MIN) return MASS_MIN;
      return q[63:0];
   endfunction

   function automatic logic signed [63:0] add_mass(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [64:0] sum;
      sum = {a[63], a} + {b[63], b};
      if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) return MASS_MAX;
      if (sum < -65'sh0_8000_0000_0000_0000) return MASS_MIN;
      return sum[63:0];
   endfunction

   task automatic assemble_element(input req_type t);
      logic [NODE_W-1:0]      corner [4];
      logic [NODE_W-1:0]      edge_n [6];
      logic signed [127:0]    ax, ay, az, bx, by, bz, cx, cy, cz, triple;
      logic signed [63:0]     corner_share, edge_share;
      corner = '{t.vertex0, t.vertex1, t.vertex2, t.vertex3};
      edge_n = '{t.edge_node0, t.edge_node1, t.edge_node2,
                 t.edge_node3, t.edge_node4, t.edge_node5};
      ax = 128'(x_coord[corner[0]]) - 128'(x_coord[corner[1]]);
      ay = 128'(y_coord[corner[0]]) - 128'(y_coord[corner[1]]);
      az = 128'(z_coord[corner[0]]) - 128'(z_coord[corner[1]]);
      bx = 128'(x_coord[corner[0]]) - 128'(x_coord[corner[2]]);
      by = 128'(y_coord[corner[0]]) - 128'(y_coord[corner[2]]);
      bz = 128'(z_coord[corner[0]]) - 128'(z_coord[corner[2]]);
      cx = 128'(x_coord[corner[0]]) - 128'(x_coord[corner[3]]);
      cy = 128'(y_coord[corner[0]]) - 128'(y_coord[corner[3]]);
      cz = 128'(z_coord[corner[0]]) - 128'(z_coord[corner[3]]);
      triple = ax * by * cz - ax * cy * bz - cx * by * az
             + bx * az * cy + cx * bz * ay - bx * cz * ay;
      // truncate toward zero, then clamp to the mass range
      corner_share = clamp_share(triple / CORNER_DIV);
      edge_share   = clamp_share((-triple) / EDGE_DIV);
      for (int k = 0; k < 4; k++)
         node_mass[corner[k]] = add_mass(node_mass[corner[k]], corner_share);
      for (int k = 0; k < 6; k++)
         node_mass[edge_n[k]] = add_mass(node_mass[edge_n[k]], edge_share);
      elements_seen = elements_seen + 32'd1;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int n = 0; n < NODES_DEFAULT; n++) node_mass[n] = '0;
         elements_seen = '0;
         mass_expected.delete();
      end else begin
         if (req_valid && !req_stall) begin
            case (req_item.action)
               ACT_LOAD_X:   x_coord[req_item.vertex0] = req_item.coordinate;
               ACT_LOAD_Y:   y_coord[req_item.vertex0] = req_item.coordinate;
               ACT_LOAD_Z:   z_coord[req_item.vertex0] = req_item.coordinate;
               ACT_ASSEMBLE: assemble_element(req_item);
               ACT_READ: begin
                  want.node          = req_item.vertex0;
                  want.mass          = node_mass[req_item.vertex0];
                  want.elements_done = elements_seen;
                  mass_expected.push_back(want);
               end
               default: ;  // unused actions do nothing
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (mass_expected.size() == 0) begin
               report_mismatch("unexpected transaction, node", 64'(rsp_item.node), '0);
            end else begin
               want = mass_expected.pop_front();
               if (rsp_item.node != want.node)
                  report_mismatch("node", 64'(rsp_item.node), 64'(want.node));
               if (rsp_item.mass != want.mass)
                  report_mismatch("mass", rsp_item.mass, want.mass);
               if (rsp_item.elements_done != want.elements_done)
                  report_mismatch("elements_done", 64'(rsp_item.elements_done),
                                  64'(want.elements_done));
            end
         end
      end
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the lumped-mass assembler: directed loads, assembles and reads
// at the coordinate extremes, then random phases of loads, element assembles,
// mass reads and unused actions under varying idle and stall rates. The checker
// predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import hrz_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int PHASE_ITEMS  = 206;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;
   int      error_count;
   int      pending_count;

   int      send_idle_pct;
   int      recv_stall_pct;
   int      hold_cycles;
   int      cycle_count;
   int      n_loads, n_elements, n_reads, n_other;
   logic [2:0] axes_written [NODES_DEFAULT];
   int      ready_nodes [$];

   hrz_lumped_mass_assembly dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   hrz_mass_checker u_mass_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: long hold-off when asked, else random stall
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic req_type random_fields();
      req_type t;
      t = $bits(req_type)'({$urandom, $urandom, $urandom, $urandom, $urandom});
      return t;
   endfunction

   task automatic send(input req_type t);
      int gaps;
      gaps = 0;
      while (gaps < 40 && $urandom_range(99) < send_idle_pct) gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= t;
      // stall settles between edges; sample it mid-cycle
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      case (t.action)
         ACT_LOAD_X, ACT_LOAD_Y, ACT_LOAD_Z: n_loads++;
         ACT_ASSEMBLE: n_elements++;
         ACT_READ:     n_reads++;
         default:      n_other++;
      endcase
   endtask

   task automatic load_coord(input logic [2:0] axis, input int node,
                             input logic [31:0] value);
      req_type t;
      t = random_fields();
      t.action     = axis;
      t.vertex0    = node[NODE_W-1:0];
      t.coordinate = value;
      if (axes_written[node] != 3'b111 && (axes_written[node] | (3'b1 << axis)) == 3'b111)
         ready_nodes.push_back(node);
      axes_written[node] |= 3'b1 << axis;
      send(t);
   endtask

   task automatic assemble(input int c0, input int c1, input int c2, input int c3,
                           input logic [NODE_W-1:0] e [6]);
      req_type t;
      t = random_fields();
      t.action  = ACT_ASSEMBLE;
      t.vertex0 = c0[NODE_W-1:0];
      t.vertex1 = c1[NODE_W-1:0];
      t.vertex2 = c2[NODE_W-1:0];
      t.vertex3 = c3[NODE_W-1:0];
      {t.edge_node0, t.edge_node1, t.edge_node2,
       t.edge_node3, t.edge_node4, t.edge_node5} = {e[0], e[1], e[2], e[3], e[4], e[5]};
      send(t);
   endtask

   task automatic read_mass(input int node);
      req_type t;
      t = random_fields();
      t.action  = ACT_READ;
      t.vertex0 = node[NODE_W-1:0];
      send(t);
   endtask

   function automatic logic [31:0] random_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5)  return 32'h7FFF_FFFF;
      if (pick < 10) return 32'h8000_0000;
      if (pick < 25) return $urandom;
      return 32'($signed($urandom_range(2097151)) - 1048576);
   endfunction

   function automatic int ready_node();
      return ready_nodes[$urandom_range(ready_nodes.size() - 1)];
   endfunction

   task automatic random_item();
      int pick, node;
      logic [NODE_W-1:0] e [6];
      req_type t;
      pick = $urandom_range(99);
      if (pick < 25) begin
         node = ($urandom_range(3) == 0) ? $urandom_range(NODES_DEFAULT - 1) : ready_node();
         load_coord(3'($urandom_range(2)), node, random_coord());
      end else if (pick < 60) begin
         for (int k = 0; k < 6; k++)
            e[k] = ($urandom_range(1) == 0) ? NODE_W'(ready_node()) : NODE_W'($urandom);
         assemble(ready_node(), ready_node(), ready_node(), ready_node(), e);
      end else if (pick < 95) begin
         read_mass(($urandom_range(3) == 0) ? $urandom_range(NODES_DEFAULT - 1)
                                            : ready_node());
      end else begin
         t = random_fields();
         t.action = 3'($urandom_range(5, 7));
         send(t);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      logic [NODE_W-1:0] e [6];
      cycle_count    = 0;
      hold_cycles    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      n_loads = 0; n_elements = 0; n_reads = 0; n_other = 0;
      for (int n = 0; n < NODES_DEFAULT; n++) axes_written[n] = 3'b000;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      rsp_stall <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme corners, repeated nodes, unused actions
      read_mass(NODES_DEFAULT - 1);
      for (int a = 0; a < 3; a++) begin
         load_coord(3'(a), 0, 32'h7FFF_FFFF);
         load_coord(3'(a), NODES_DEFAULT - 1, 32'h8000_0000);
      end
      load_coord(ACT_LOAD_X, 1, 32'h7FFF_FFFF);
      load_coord(ACT_LOAD_Y, 1, 32'h8000_0000);
      load_coord(ACT_LOAD_Z, 1, 32'h0000_0000);
      load_coord(ACT_LOAD_X, 2, 32'h8000_0000);
      load_coord(ACT_LOAD_Y, 2, 32'h0001_0000);
      load_coord(ACT_LOAD_Z, 2, 32'h7FFF_FFFF);
      e = '{12'd5, 12'd5, 12'd4095, 12'd0, 12'd7, 12'd5};
      assemble(0, NODES_DEFAULT - 1, 1, 2, e);
      assemble(0, 2, 1, NODES_DEFAULT - 1, e);
      e = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
      assemble(0, 0, 0, 0, e);
      read_mass(0);
      read_mass(5);
      read_mass(NODES_DEFAULT - 1);
      read_mass(3000);
      for (int a = 5; a <= 7; a++) begin
         send(random_fields() | {3'(a), 152'd0});
      end
      drain();

      // random phases over the idle and stall mixes
      for (int n = 0; n < 48; n++)
         for (int a = 0; a < 3; a++)
            if (axes_written[n * 83 % NODES_DEFAULT][a] == 1'b0)
               load_coord(3'(a), n * 83 % NODES_DEFAULT, random_coord());
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         if (phase == 4) begin
            // back-pressure: a result waits while further reads are held off
            hold_cycles = 3000;
            for (int k = 0; k < 40; k++) read_mass(ready_node());
         end
         for (int k = 0; k < PHASE_ITEMS; k++) random_item();
         drain();
      end

      $display("Sent %0d loads, %0d element assembles, %0d mass reads, %0d unused items",
               n_loads, n_elements, n_reads, n_other);
      $display("Coordinates at full range, saturating masses, repeated nodes, stall mixes");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
